[sv/lsbse_pkg.sv]
// ----------------------------------------------------------------------------
// lsbse_pkg
// shared types and constants of the lsb embed / extract core
// ----------------------------------------------------------------------------
`default_nettype none

package lsbse_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 2'd3;

    localparam logic [2:0] LAST_BIT = 3'd7;

    localparam logic       MODE_EXTRACT = 1'b0;
    localparam logic       MODE_EMBED   = 1'b1;

    localparam logic [1:0] ST_NONE   = 2'd0;
    localparam logic [1:0] ST_CHAR   = 2'd1;
    localparam logic [1:0] ST_NO_MSG = 2'd2;
    localparam logic [1:0] ST_END    = 2'd3;

    typedef struct packed {
        logic        mode;
        logic [15:0] header_bytes;
        logic [7:0]  start_marker;
        logic [7:0]  end_marker;
    } t_cfg;

    typedef struct packed {
        logic       frame_start;
        logic [7:0] cover_byte;
        logic [7:0] message_char;
        logic       char_present;
    } t_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [7:0] char_out;
        logic [1:0] status;
    } t_result;

endpackage

`default_nettype wire

[sv/lsb_stego_embed_extract_core.sv]
// ----------------------------------------------------------------------------
// lsb_stego_embed_extract_core
// hides message characters in image byte lsbs, or recovers them
// ----------------------------------------------------------------------------
// One image byte enters per beat on the s_axis channel, one result beat
// leaves per input beat on the m_axis channel, in order.
// Registers are set through i_cfg_we / i_cfg_idx / i_cfg_wdata (0 mode,
// 1 header byte count, 2 start marker, 3 end marker); the user must write
// them only while the block is idle, the block itself does not enforce it.
// Beats pass an input register, then byte logic, into the result register.
// Throughput is one beat per cycle while the receiver keeps up; the frame
// state update (bit slot, gather shift, header count) allows that rate.
// When the receiver stalls, the result register holds its beat, the input
// register takes one more beat only if empty, then s_axis_tready drops.
// Synchronous reset empties both stages, loads the register defaults
// (extract, 54 header bytes, markers 2 and 3) and clears frame state, so
// bytes before the first frame start are treated as payload.
// ----------------------------------------------------------------------------
`default_nettype none

module lsb_stego_embed_extract_core
    import lsbse_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [15:0]           s_axis_tdata,  // cover_byte, message_char
    input  wire logic [1:0]            s_axis_tuser,  // frame_start, char_present
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [15:0]                m_axis_tdata,  // out_byte, char_out
    output logic [1:0]                 m_axis_tuser   // status
);

    t_cfg    r_cfg;
    t_item   in_item;
    t_item   q_item;
    logic    q_valid;
    logic    take;
    t_result result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode         <= MODE_EXTRACT;
            r_cfg.header_bytes <= 16'd54;
            r_cfg.start_marker <= 8'd2;
            r_cfg.end_marker   <= 8'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:         r_cfg.mode         <= i_cfg_wdata[0];
                CFG_HEADER_BYTES: r_cfg.header_bytes <= i_cfg_wdata;
                CFG_START_MARKER: r_cfg.start_marker <= i_cfg_wdata[7:0];
                CFG_END_MARKER:   r_cfg.end_marker   <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    assign in_item.frame_start  = s_axis_tuser[0];
    assign in_item.char_present = s_axis_tuser[1];
    assign in_item.cover_byte   = s_axis_tdata[7:0];
    assign in_item.message_char = s_axis_tdata[15:8];

    lsbse_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (q_valid),
        .i_take  (take),
        .o_item  (q_item)
    );

    lsbse_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (q_valid),
        .i_item   (q_item),
        .o_take   (take),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    assign m_axis_tdata = {result.char_out, result.out_byte};
    assign m_axis_tuser = result.status;

endmodule

`default_nettype wire

[sv/lsbse_in_reg.sv]
// ----------------------------------------------------------------------------
// lsbse_in_reg
// input register stage, holds one beat while the result side is stalled
// ----------------------------------------------------------------------------
`default_nettype none

module lsbse_in_reg
    import lsbse_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_item i_item,
    output logic       o_valid,
    input  wire logic  i_take,
    output t_item      o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

[sv/lsbse_step.sv]
// ----------------------------------------------------------------------------
// lsbse_step
// per-byte embed / extract logic, frame state and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module lsbse_step
    import lsbse_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_valid,
    input  wire t_item i_item,
    output logic       o_take,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_result    o_result
);

    logic [15:0] r_header_left, n_header_left;
    logic [2:0]  r_bit_slot, n_bit_slot;
    logic [7:0]  r_held_char, n_held_char;
    logic [7:0]  r_gather_shift, n_gather_shift;
    logic        r_first_pending, n_first_pending;
    logic        r_finished, n_finished;
    logic        r_out_valid, n_out_valid;
    t_result     r_result, n_result;

    // state as seen after an optional frame start on this beat
    logic [15:0] hl;
    logic [2:0]  slot;
    logic [7:0]  held;
    logic [7:0]  gs;
    logic        fcp;
    logic        fin;

    assign o_take   = i_valid && (!r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_result = r_result;

    always_comb begin
        hl   = i_item.frame_start ? i_cfg.header_bytes : r_header_left;
        slot = i_item.frame_start ? 3'd0 : r_bit_slot;
        held = i_item.frame_start ? 8'd0 : r_held_char;
        gs   = i_item.frame_start ? 8'd0 : r_gather_shift;
        fcp  = i_item.frame_start ? 1'b1 : r_first_pending;
        fin  = i_item.frame_start ? 1'b0 : r_finished;

        n_header_left   = hl;
        n_bit_slot      = slot;
        n_held_char     = held;
        n_gather_shift  = gs;
        n_first_pending = fcp;
        n_finished      = fin;

        n_result.out_byte = i_item.cover_byte;
        n_result.char_out = 8'd0;
        n_result.status   = ST_NONE;

        if (hl != 16'd0) begin
            n_header_left = hl - 16'd1;
        end else if (fin) begin
            // pass through until next frame
        end else if (i_cfg.mode == MODE_EMBED) begin
            if (slot == 3'd0 && !i_item.char_present) begin
                n_finished = 1'b1;
            end else begin
                if (slot == 3'd0) begin
                    n_held_char = i_item.message_char;
                end
                n_result.out_byte = {i_item.cover_byte[7:1], n_held_char[LAST_BIT - slot]};
                n_bit_slot        = slot + 3'd1;
            end
        end else begin
            n_gather_shift = {gs[6:0], i_item.cover_byte[0]};
            n_bit_slot     = slot + 3'd1;
            if (slot == LAST_BIT) begin
                if (fcp) begin
                    n_first_pending = 1'b0;
                    if (n_gather_shift != i_cfg.start_marker) begin
                        n_result.status = ST_NO_MSG;
                        n_finished      = 1'b1;
                    end else if (n_gather_shift == i_cfg.end_marker) begin
                        n_result.status = ST_END;
                        n_finished      = 1'b1;
                    end
                end else if (n_gather_shift == i_cfg.end_marker) begin
                    n_result.status = ST_END;
                    n_finished      = 1'b1;
                end else begin
                    n_result.status   = ST_CHAR;
                    n_result.char_out = n_gather_shift;
                end
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_take) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_left   <= 16'd0;
            r_bit_slot      <= 3'd0;
            r_held_char     <= 8'd0;
            r_gather_shift  <= 8'd0;
            r_first_pending <= 1'b1;
            r_finished      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_take) begin
                r_header_left   <= n_header_left;
                r_bit_slot      <= n_bit_slot;
                r_held_char     <= n_held_char;
                r_gather_shift  <= n_gather_shift;
                r_first_pending <= n_first_pending;
                r_finished      <= n_finished;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_result <= n_result;
        end
    end

endmodule

`default_nettype wire

[tb/lsb_stego_checker.sv]
// ----------------------------------------------------------------------------
// lsb_stego_checker
// watches the byte streams of the lsb embed / extract core and checks results
// ----------------------------------------------------------------------------
// Follows register writes and accepted input beats, predicts the result beat
// of each input beat, and compares every accepted result beat field by field
// with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module lsb_stego_checker
    import lsbse_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_s_axis_tvalid,
    input  wire logic                  i_s_axis_tready,
    input  wire logic [15:0]           i_s_axis_tdata,  // cover_byte, message_char
    input  wire logic [1:0]            i_s_axis_tuser,  // frame_start, char_present
    input  wire logic                  i_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    input  wire logic [15:0]           i_m_axis_tdata,  // out_byte, char_out
    input  wire logic [1:0]            i_m_axis_tuser,  // status
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t_cfg        regs;
    logic [15:0] hdr_left;
    logic [2:0]  slot;
    logic [7:0]  held;
    logic [7:0]  gather;
    logic        first_pending;
    logic        frame_done;
    t_result     stego_result_q[$];
    int          mismatches = 0;

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic t_result stego_byte_result(input t_item it);
        t_result r;
        r.out_byte = it.cover_byte;
        r.char_out = 8'h00;
        r.status   = ST_NONE;
        if (it.frame_start) begin
            hdr_left      = regs.header_bytes;
            slot          = '0;
            held          = '0;
            gather        = '0;
            first_pending = 1'b1;
            frame_done    = 1'b0;
        end
        if (hdr_left != 0) begin
            hdr_left = hdr_left - 16'd1;
        end else if (!frame_done) begin
            if (regs.mode == MODE_EMBED) begin
                // a slot start with nothing to hide ends embedding for the frame
                if (slot == 0 && !it.char_present) begin
                    frame_done = 1'b1;
                end else begin
                    if (slot == 0)
                        held = it.message_char;
                    r.out_byte = {it.cover_byte[7:1], held[LAST_BIT - slot]};
                    slot = slot + 3'd1;
                end
            end else begin
                gather = {gather[6:0], it.cover_byte[0]};
                slot   = slot + 3'd1;
                if (slot == 0) begin
                    if (first_pending) begin
                        first_pending = 1'b0;
                        if (gather != regs.start_marker) begin
                            r.status   = ST_NO_MSG;
                            frame_done = 1'b1;
                        end else if (gather == regs.end_marker) begin
                            r.status   = ST_END;
                            frame_done = 1'b1;
                        end
                    end else if (gather == regs.end_marker) begin
                        r.status   = ST_END;
                        frame_done = 1'b1;
                    end else begin
                        r.status   = ST_CHAR;
                        r.char_out = gather;
                    end
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_item   it;
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            regs = '{mode: MODE_EXTRACT, header_bytes: 16'd54,
                     start_marker: 8'd2, end_marker: 8'd3};
            hdr_left      = '0;
            slot          = '0;
            held          = '0;
            gather        = '0;
            first_pending = 1'b1;
            frame_done    = 1'b0;
            stego_result_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE:         regs.mode         = i_cfg_wdata[0];
                    CFG_HEADER_BYTES: regs.header_bytes = i_cfg_wdata;
                    CFG_START_MARKER: regs.start_marker = i_cfg_wdata[7:0];
                    CFG_END_MARKER:   regs.end_marker   = i_cfg_wdata[7:0];
                    default: ;
                endcase
            end
            // result beat first: it always belongs to an older input beat
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.out_byte = i_m_axis_tdata[7:0];
                got.char_out = i_m_axis_tdata[15:8];
                got.status   = i_m_axis_tuser;
                if (stego_result_q.size() == 0) begin
                    $display("%0t: result beat with none expected, expected none, got %0h/%0h/%0h",
                             $time, got.out_byte, got.char_out, got.status);
                    mismatches++;
                end else begin
                    want = stego_result_q.pop_front();
                    check_field("out_byte", want.out_byte, got.out_byte);
                    check_field("char_out", want.char_out, got.char_out);
                    check_field("status", 8'(want.status), 8'(got.status));
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                it.frame_start  = i_s_axis_tuser[0];
                it.char_present = i_s_axis_tuser[1];
                it.cover_byte   = i_s_axis_tdata[7:0];
                it.message_char = i_s_axis_tdata[15:8];
                stego_result_q.push_back(stego_byte_result(it));
            end
        end
        o_pending    <= stego_result_q.size();
        o_fail_count <= mismatches;
    end

endmodule

`default_nettype wire

[tb/lsb_stego_embed_extract_core_tb.sv]
// ----------------------------------------------------------------------------
// lsb_stego_embed_extract_core_tb
// stimulus and verdict for the lsb embed / extract core
// ----------------------------------------------------------------------------
// Sends a short directed run, then frames of image bytes under several
// register settings: mostly well-formed hidden messages or embed slots with
// random content, some truncated frames and some noise. Both stream sides
// idle at random. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module lsb_stego_embed_extract_core_tb;
    import lsbse_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata = '0;   // cover_byte, message_char
    logic [1:0]            s_axis_tuser = '0;   // frame_start, char_present
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [15:0]           m_axis_tdata;        // out_byte, char_out
    logic [1:0]            m_axis_tuser;        // status

    int    fail_count;
    int    pending;
    int    cycle_count = 0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    t_cfg  cur_cfg;
    t_item beats[$];

    lsb_stego_embed_extract_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    lsb_stego_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tuser  (m_axis_tuser),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic t_item random_byte_beat();
        t_item it;
        it.frame_start  = 1'b0;
        it.cover_byte   = 8'($urandom);
        it.message_char = 8'($urandom);
        it.char_present = 1'($urandom);
        return it;
    endfunction

    // one character spread over the lsbs of eight bytes, msb first
    task automatic hide_char(ref t_item fq[$], input logic [7:0] ch);
        t_item it;
        for (int b = 7; b >= 0; b--) begin
            it = random_byte_beat();
            it.cover_byte[0] = ch[b];
            fq.push_back(it);
        end
    endtask

    task automatic append_frame(ref t_item fq[$], input bit lead_start);
        t_item      it;
        int         first_idx;
        int         n_hdr;
        int         n_chars;
        int         kind;
        logic [7:0] ch;
        first_idx = fq.size();
        kind      = $urandom_range(99);
        if (kind < 20) begin
            repeat ($urandom_range(40, 8)) begin
                it = random_byte_beat();
                it.frame_start = ($urandom_range(15) == 0);
                fq.push_back(it);
            end
        end else begin
            n_hdr   = (cur_cfg.header_bytes > 40) ? 40 : int'(cur_cfg.header_bytes);
            n_chars = $urandom_range(6);
            repeat (n_hdr) fq.push_back(random_byte_beat());
            if (cur_cfg.mode == MODE_EMBED) begin
                repeat (n_chars) begin
                    it = random_byte_beat();
                    it.char_present = 1'b1;
                    fq.push_back(it);
                    repeat (7) fq.push_back(random_byte_beat());
                end
                it = random_byte_beat();
                it.char_present = 1'b0;
                fq.push_back(it);
            end else begin
                hide_char(fq, ($urandom_range(9) == 0) ? 8'($urandom) : cur_cfg.start_marker);
                repeat (n_chars) begin
                    ch = 8'($urandom);
                    if (ch == cur_cfg.end_marker)
                        ch = ~ch;
                    hide_char(fq, ch);
                end
                hide_char(fq, ($urandom_range(9) == 0) ? 8'($urandom) : cur_cfg.end_marker);
            end
            repeat ($urandom_range(5)) fq.push_back(random_byte_beat());
            // cut some frames short, the next frame start takes over
            if (kind < 28)
                repeat ($urandom_range(fq.size() - first_idx - 1)) void'(fq.pop_back());
        end
        fq[first_idx].frame_start = lead_start;
    endtask

    task automatic send_byte_beat(input t_item it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.message_char, it.cover_byte};
        s_axis_tuser  <= {it.char_present, it.frame_start};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_beats(ref t_item fq[$]);
        foreach (fq[i])
            send_byte_beat(fq[i]);
        fq.delete();
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // unused upper bits carry random junk
    task automatic write_regs(input t_cfg c);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_MODE;
        i_cfg_wdata <= {15'($urandom), c.mode};
        @(posedge i_clk);
        i_cfg_idx   <= CFG_HEADER_BYTES;
        i_cfg_wdata <= c.header_bytes;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_START_MARKER;
        i_cfg_wdata <= {8'($urandom), c.start_marker};
        @(posedge i_clk);
        i_cfg_idx   <= CFG_END_MARKER;
        i_cfg_wdata <= {8'($urandom), c.end_marker};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_idling(input int profile);
        case (profile)
            0: begin
                send_idle_pct   = 9;
                recv_stall_pct <= 87;
            end
            1: begin
                send_idle_pct   = 87;
                recv_stall_pct <= 9;
            end
            default: begin
                send_idle_pct   = 0;
                recv_stall_pct <= 0;
            end
        endcase
    endtask

    initial begin
        t_item it;
        int    sent;
        int    target;
        bit    carry_on;
        cur_cfg = '{mode: MODE_EXTRACT, header_bytes: 16'd54,
                    start_marker: 8'd2, end_marker: 8'd3};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_idling(0);

        // payload before any frame start, default registers: start then end marker
        hide_char(beats, cur_cfg.start_marker);
        hide_char(beats, cur_cfg.end_marker);
        beats[0].cover_byte = 8'h00;
        beats[6].cover_byte = 8'hFF;
        send_beats(beats);
        wait_drained();

        // embed one character after a one byte header, then a slot with no character
        cur_cfg = '{mode: MODE_EMBED, header_bytes: 16'd1, start_marker: 8'hFF, end_marker: 8'h00};
        write_regs(cur_cfg);
        it = random_byte_beat();
        it.frame_start = 1'b1;
        beats.push_back(it);
        for (int i = 0; i < 8; i++) begin
            it = random_byte_beat();
            it.cover_byte   = i[0] ? 8'hFF : 8'h00;
            it.message_char = (i == 0) ? 8'h5A : (i[0] ? 8'hFF : 8'h00);
            it.char_present = (i == 0) || i[1];
            beats.push_back(it);
        end
        it = random_byte_beat();
        it.char_present = 1'b0;
        beats.push_back(it);
        send_beats(beats);

        for (int p = 0; p < 9; p++) begin
            wait_drained();
            set_idling(p / 3);
            cur_cfg.mode         = p[0] ? MODE_EMBED : MODE_EXTRACT;
            cur_cfg.header_bytes = (p == 0) ? 16'd0 :
                                   (p == 4) ? 16'hFFFF : 16'($urandom_range(6));
            cur_cfg.start_marker = 8'($urandom);
            cur_cfg.end_marker   = 8'($urandom);
            if (p == 2)
                cur_cfg.end_marker = cur_cfg.start_marker;
            if (p == 6) begin
                cur_cfg.start_marker = 8'h00;
                cur_cfg.end_marker   = 8'hFF;
            end
            if (p == 8) begin
                cur_cfg.start_marker = 8'hFF;
                cur_cfg.end_marker   = 8'h00;
            end
            write_regs(cur_cfg);
            // some phases pick up the previous frame where it stopped
            carry_on = (p % 3 == 1) || ($urandom_range(2) == 0);
            target   = (p == 4) ? 30 : 120;
            sent     = 0;
            while (sent < target) begin
                append_frame(beats, !carry_on);
                carry_on = 1'b0;
                sent += beats.size();
                send_beats(beats);
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
